@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on the rising edge of clk, disabled during reset.
`define ASSERT_AT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition that must never be seen on a rising edge of clk outside reset.
`define ASSERT_NEVER_AT_CLK(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`endif

@@ hw/rtl/fbc_pkg.sv @@
// Types, tables and round functions of the Feistel block cipher core.
package fbc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MD5,
    ST_MDFIN,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic shift_left;
    logic shift_right;
  } chain_ctl_t;

  typedef struct packed {
    logic init;
    logic run;
  } md5_ctl_t;

  typedef struct packed {
    logic last;
  } md5_stat_t;

  localparam logic [31:0] MD5_IV_A = 32'h67452301;
  localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
  localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
  localparam logic [31:0] MD5_IV_D = 32'h10325476;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,
    32'hf57c0faf,32'h4787c62a,32'ha8304613,32'hfd469501,
    32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
    32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,
    32'hf61e2562,32'hc040b340,32'h265e5a51,32'he9b6c7aa,
    32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
    32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,
    32'ha9e3e905,32'hfcefa3f8,32'h676f02d9,32'h8d2a4c8a,
    32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
    32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,
    32'h289b7ec6,32'heaa127fa,32'hd4ef3085,32'h04881d05,
    32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
    32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,
    32'h655b59c3,32'h8f0ccc92,32'hffeff47d,32'h85845dd1,
    32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
    32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391
  };

  localparam logic [4:0] MD5_R [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [63:0] add_words(input logic [63:0] a, input logic [63:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = a[63:32] + b[63:32];
    lo = a[31:0] + b[31:0];
    return {hi, lo};
  endfunction

  function automatic logic [63:0] mix(input logic [63:0] a, input logic [63:0] k,
                                      input logic [1:0] m);
    logic [63:0] y;
    case (m)
      2'd0: y = a ^ k;
      2'd1: y = add_words(a, k);
      2'd2: y = add_words(a ^ k, k);
      default: y = add_words(a, k) ^ k;
    endcase
    return y;
  endfunction

endpackage

@@ hw/rtl/fbc_key_cell.sv @@
// One cell of the round key chain, holding one 128-bit round key.
module fbc_key_cell (
  input  logic                clk,
  input  fbc_pkg::chain_ctl_t ctl,
  input  logic [127:0]        from_left,
  input  logic [127:0]        from_right,
  output logic [127:0]        q
);

  always_ff @(posedge clk) begin
    if (ctl.shift_left) begin
      q <= from_right;
    end else if (ctl.shift_right) begin
      q <= from_left;
    end
  end

endmodule

@@ hw/rtl/fbc_md5_unit.sv @@
// Iterative MD5 of one 16-byte message, one of the 64 steps per cycle while run is set.
module fbc_md5_unit (
  input  logic               clk,
  input  fbc_pkg::md5_ctl_t  ctl,
  input  logic [127:0]       msg,
  output fbc_pkg::md5_stat_t stat,
  output logic [127:0]       digest
);

  logic [31:0] a, b, c, d;
  logic [5:0]  cnt;
  logic [31:0] w [16];
  logic [31:0] f;
  logic [3:0]  g;
  logic [31:0] sum;
  logic [63:0] rot;
  logic [4:0]  sh;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w[i] = 32'h0;
    end
    w[0]  = fbc_pkg::bswap32(msg[127:96]);
    w[1]  = fbc_pkg::bswap32(msg[95:64]);
    w[2]  = fbc_pkg::bswap32(msg[63:32]);
    w[3]  = fbc_pkg::bswap32(msg[31:0]);
    w[4]  = 32'h80;
    w[14] = 32'h80;
  end

  always_comb begin
    case (cnt[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = cnt[3:0];
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = 4'(cnt[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'(cnt[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = c ^ (b | ~d);
        g = 4'(cnt[3:0] * 4'd7);
      end
    endcase
    sh  = fbc_pkg::MD5_R[{cnt[5:4], cnt[1:0]}];
    sum = a + f + fbc_pkg::MD5_K[cnt] + w[g];
    rot = {sum, sum} << sh;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      a   <= fbc_pkg::MD5_IV_A;
      b   <= fbc_pkg::MD5_IV_B;
      c   <= fbc_pkg::MD5_IV_C;
      d   <= fbc_pkg::MD5_IV_D;
      cnt <= 6'd0;
    end else if (ctl.run) begin
      a   <= d;
      d   <= c;
      c   <= b;
      b   <= b + rot[63:32];
      cnt <= cnt + 6'd1;
    end
  end

  assign stat.last = (cnt == 6'd63);
  assign digest = {fbc_pkg::bswap32(fbc_pkg::MD5_IV_A + a),
                   fbc_pkg::bswap32(fbc_pkg::MD5_IV_B + b),
                   fbc_pkg::bswap32(fbc_pkg::MD5_IV_C + c),
                   fbc_pkg::bswap32(fbc_pkg::MD5_IV_D + d)};

endmodule

@@ hw/rtl/fbc_round_unit.sv @@
// One Feistel round function: S-box layer, key mixing and the xor into the left half.
module fbc_round_unit (
  input  logic [63:0]  left_in,
  input  logic [63:0]  right_in,
  input  logic [127:0] round_key,
  output logic [63:0]  new_right
);

  logic [63:0] s;
  logic [63:0] k;
  logic [1:0]  m;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      s[8*i +: 8] = fbc_pkg::SBOX[right_in[8*i +: 8]];
    end
    m = round_key[1:0];
    k = fbc_pkg::mix(round_key[127:64], round_key[63:0], m);
    new_right = left_in ^ fbc_pkg::mix(s, k, m);
  end

endmodule

@@ hw/rtl/feistel_block_cipher_md5_keys_core.sv @@
// Top level of the Feistel block cipher core with an MD5 round key chain.
//   channel  | direction | handshake            | payload
//   s_*      | in        | s_tvalid / s_tready  | s_tdata blocks, s_tuser function
//   m_*      | out       | m_tvalid / m_tready  | m_tdata result blocks
//   apb      | in        | psel, penable, pwrite| first round key halves
// A word runs its ROUND_COUNT rounds on the shared round unit as the key chain rotates,
// so with valid keys a new word is taken only once the last one's rounds finish.
// After reset or a key write, the first word rebuilds the chain first: the first key
// goes in, then each further key is the 64-step MD5 unit's digest of the key before it.
// A new word is taken once the rounds finish, even if the result still waits.
// The last round holds while the output register is full and not taken.
module feistel_block_cipher_md5_keys_core #(
  parameter int ROUND_COUNT = 17
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // left_half[63:0], right_half[127:64]
  input  logic [0:0]   s_tuser,   // func[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // left_out[63:0], right_out[127:64]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int CW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int KW = $clog2(ROUND_COUNT + 1);

  fbc_pkg::state_t     state, state_next;
  fbc_pkg::chain_ctl_t chain_ctl;
  fbc_pkg::md5_ctl_t   md5_ctl;
  fbc_pkg::md5_stat_t  md5_stat;

  logic [63:0]  first_key_high, first_key_low;
  logic         keys_valid;
  logic         func;
  logic [63:0]  fl, fr;
  logic [CW-1:0] rnd;
  logic [KW-1:0] kcnt;
  logic [127:0] key_q [ROUND_COUNT];
  logic [127:0] ins_word;
  logic [127:0] digest;
  logic [127:0] round_key;
  logic [63:0]  nr;
  logic         accept, cfg_wr, fin_ok, last_round, advance, finish, build_start;
  logic         build_last;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign accept     = s_tvalid && s_tready;
  assign fin_ok     = !m_tvalid || m_tready;
  assign last_round = (rnd == CW'(ROUND_COUNT - 1));
  assign build_start = accept && !keys_valid;
  assign build_last = (kcnt == KW'(ROUND_COUNT - 1));
  assign prdata     = paddr[3] ? first_key_low : first_key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_key_high <= 64'h0;
      first_key_low  <= 64'h0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        first_key_low <= pwdata;
      end else begin
        first_key_high <= pwdata;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fbc_pkg::ST_IDLE: begin
        if (accept) begin
          if (keys_valid || ROUND_COUNT == 1) begin
            state_next = fbc_pkg::ST_ROUND;
          end else begin
            state_next = fbc_pkg::ST_MD5;
          end
        end
      end
      fbc_pkg::ST_MD5: begin
        if (md5_stat.last) begin
          state_next = fbc_pkg::ST_MDFIN;
        end
      end
      fbc_pkg::ST_MDFIN: begin
        state_next = build_last ? fbc_pkg::ST_ROUND : fbc_pkg::ST_MD5;
      end
      fbc_pkg::ST_ROUND: begin
        if (last_round && fin_ok) begin
          state_next = fbc_pkg::ST_IDLE;
        end
      end
      default: state_next = fbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready              = (state == fbc_pkg::ST_IDLE);
    advance               = (state == fbc_pkg::ST_ROUND) && (!last_round || fin_ok);
    finish                = advance && last_round;
    chain_ctl.shift_left  = 1'b0;
    chain_ctl.shift_right = 1'b0;
    md5_ctl.init          = 1'b0;
    md5_ctl.run           = (state == fbc_pkg::ST_MD5);
    ins_word              = key_q[0];
    case (state)
      fbc_pkg::ST_IDLE: begin
        chain_ctl.shift_left = build_start;
        md5_ctl.init         = build_start;
        ins_word             = {first_key_high, first_key_low};
      end
      fbc_pkg::ST_MDFIN: begin
        chain_ctl.shift_left = 1'b1;
        md5_ctl.init         = !build_last;
        ins_word             = digest;
      end
      fbc_pkg::ST_ROUND: begin
        chain_ctl.shift_left  = advance && !func;
        chain_ctl.shift_right = advance && func;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fbc_pkg::ST_IDLE;
      keys_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      rnd        <= '0;
      kcnt       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        keys_valid <= 1'b0;
      end else if ((build_start && ROUND_COUNT == 1) ||
                   (state == fbc_pkg::ST_MDFIN && build_last)) begin
        keys_valid <= 1'b1;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        rnd <= '0;
      end else if (advance) begin
        rnd <= rnd + CW'(1);
      end
      if (build_start) begin
        kcnt <= KW'(1);
      end else if (state == fbc_pkg::ST_MDFIN) begin
        kcnt <= kcnt + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func <= s_tuser[0];
      fl   <= s_tuser[0] ? s_tdata[127:64] : s_tdata[63:0];
      fr   <= s_tuser[0] ? s_tdata[63:0] : s_tdata[127:64];
    end else if (advance) begin
      fl <= fr;
      fr <= nr;
    end
    if (finish) begin
      m_tdata <= func ? {fr, nr} : {nr, fr};
    end
  end

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
    logic [127:0] from_left, from_right;
    if (i == 0) begin : g_first
      assign from_left = key_q[ROUND_COUNT-1];
    end else begin : g_mid_l
      assign from_left = key_q[i-1];
    end
    if (i == ROUND_COUNT - 1) begin : g_last
      assign from_right = ins_word;
    end else begin : g_mid_r
      assign from_right = key_q[i+1];
    end
    fbc_key_cell u_cell (
      .clk        (clk),
      .ctl        (chain_ctl),
      .from_left  (from_left),
      .from_right (from_right),
      .q          (key_q[i])
    );
  end

  fbc_md5_unit u_md5 (
    .clk    (clk),
    .ctl    (md5_ctl),
    .msg    (key_q[ROUND_COUNT-1]),
    .stat   (md5_stat),
    .digest (digest)
  );

  assign round_key = func ? key_q[ROUND_COUNT-1] : key_q[0];

  fbc_round_unit u_round (
    .left_in   (fl),
    .right_in  (fr),
    .round_key (round_key),
    .new_right (nr)
  );

endmodule

@@ hw/rtl/fbc_checker.sv @@
// Port-level checker for the cipher core and its bind statement.
`include "assert_macros.svh"

module fbc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  `ASSERT_AT_CLK(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  `ASSERT_AT_CLK(a_no_instant_result, clk, rst, (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
  `ASSERT_AT_CLK(a_out_valid_holds, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)
  `ASSERT_AT_CLK(a_out_data_holds, clk, rst, (m_tvalid && !m_tready) |=> $stable(m_tdata))
  `ASSERT_NEVER_AT_CLK(a_handshake_known, clk, rst, $isunknown({s_tready, m_tvalid}))

endmodule

bind feistel_block_cipher_md5_keys_core fbc_checker u_fbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
